@@ rtl/core/bsa_pkg.sv @@
// bsa_pkg: shared types, constants and helpers of the bitmap slot allocator
// used by bsa_word_mem, bsa_seq and bitmap_slot_allocator; no dependencies
`default_nettype none

package bsa_pkg;

   // fixed field widths
   localparam int WORD_BITS = 32;
   localparam int BIT_W     = 5;
   localparam int IDX_W     = 10;
   localparam int CNT_W     = 11;
   localparam int CAP_W     = 16;

   // largest word count that a slot index can address
   localparam int ADDR_WORDS = 1 << (IDX_W - BIT_W);

   localparam logic [WORD_BITS-1:0] ALL_ONES  = 32'hffff_ffff;
   localparam logic [WORD_BITS-1:0] ZERO_WORD = 32'h0000_0000;

   // operation codes
   localparam logic [1:0] MODE_TEST  = 2'd0;
   localparam logic [1:0] MODE_SET   = 2'd1;
   localparam logic [1:0] MODE_RESET = 2'd2;
   localparam logic [1:0] MODE_FLIP  = 2'd3;

   // input item, mode in the lowest bits
   typedef struct packed {
      logic [CNT_W-1:0] request_count;
      logic [IDX_W-1:0] slot_index;
      logic [1:0]       mode;
   } req_type;

   // result item, bit_before in the lowest bits
   typedef struct packed {
      logic             index_error;
      logic             pool_empty;
      logic             pool_full;
      logic             has_space_many;
      logic             none_set;
      logic             any_set;
      logic             all_set;
      logic             no_free_found;
      logic [CNT_W-1:0] first_free;
      logic [CNT_W-1:0] free_count;
      logic [CNT_W-1:0] used_count;
      logic             bit_before;
   } rsp_type;

   localparam int REQ_BITS = $bits(req_type);
   localparam int RSP_BITS = $bits(rsp_type);

   // position of the lowest set bit; zero when none is set
   function automatic logic [BIT_W-1:0] lowest_one(input logic [WORD_BITS-1:0] vec);
      logic [BIT_W-1:0] pos;
      pos = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (vec[i]) begin
            pos = BIT_W'(i);
         end
      end
      return pos;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/bsa_word_mem.sv @@
// bsa_word_mem: occupancy word memory, one write and one read port,
// registered read data; per-word valid bits make unwritten words read as zero
// depends on bsa_pkg
`default_nettype none

module bsa_word_mem #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 rd_en,
   input  wire  [AW-1:0]                       rd_addr,
   output logic [bsa_pkg::WORD_BITS-1:0]       rd_data,
   input  wire                                 wr_en,
   input  wire  [AW-1:0]                       wr_addr,
   input  wire  [bsa_pkg::WORD_BITS-1:0]       wr_data
);
   import bsa_pkg::*;

   logic [WORD_BITS-1:0] word_mem [DEPTH];
   logic [WORD_BITS-1:0] rd_q_ff;
   logic                 rd_vld_ff;
   logic [DEPTH-1:0]     vld_ff;

   // storage array and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         word_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= word_mem[rd_addr];
      end
   end

   // valid bits, cleared at once by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   // a word never written reads as cleared
   assign rd_data = rd_vld_ff ? rd_q_ff : ZERO_WORD;

endmodule

`default_nettype wire

@@ rtl/core/bsa_seq.sv @@
// bsa_seq: sequencer of the allocator: read-modify-write of one occupancy word,
// counters, tracked lowest free slot and the word-by-word free search
// depends on bsa_pkg; drives bsa_word_mem
`default_nettype none

module bsa_seq #(
   parameter int WORD_COUNT = 32,
   parameter int MEM_WORDS  = 32,
   parameter int AW         = 5
) (
   input  wire                      clock,
   input  wire                      reset,
   // accepted item
   input  wire                      req_valid,
   output logic                     req_ready,
   input  wire  bsa_pkg::req_type   req,
   // word memory
   output logic                     rd_en,
   output logic [AW-1:0]            rd_addr,
   input  wire  [bsa_pkg::WORD_BITS-1:0] rd_data,
   output logic                     wr_en,
   output logic [AW-1:0]            wr_addr,
   output logic [bsa_pkg::WORD_BITS-1:0] wr_data,
   // result
   input  wire                      rsp_space,
   output logic                     rsp_load,
   output bsa_pkg::rsp_type         rsp
);
   import bsa_pkg::*;

   localparam int CAPACITY = WORD_COUNT * WORD_BITS;
   localparam int CNT_MAX  = (CAPACITY > 2047) ? 2047 : CAPACITY;
   localparam int NZ_W     = $clog2(MEM_WORDS + 1);

   localparam logic [CAP_W-1:0] CAP_LIMIT  = CAP_W'(CAPACITY);
   localparam logic [CNT_W-1:0] CNT_TOP    = CNT_W'(CNT_MAX);
   localparam logic [CNT_W-1:0] MEM_END    = CNT_W'(MEM_WORDS * WORD_BITS);
   localparam logic [AW-1:0]    LAST_ADDR  = AW'(MEM_WORDS - 1);
   localparam logic [NZ_W-1:0]  WORDS_HELD = NZ_W'(MEM_WORDS);
   localparam bit               ZERO_TAIL  = (WORD_COUNT > MEM_WORDS);

   // state codes
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_MODIFY = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_FETCH  = 3'd3;
   localparam logic [2:0] ST_REPORT = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [1:0]           mode_ff, mode_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [CNT_W-1:0]     reqcnt_ff, reqcnt_in;
   logic                 err_ff, err_in;
   logic                 before_ff, before_in;
   logic                 nofree_ff, nofree_in;
   logic [CNT_W-1:0]     used_ff, used_in;
   logic [CNT_W-1:0]     free_ff, free_in;
   logic [CNT_W-1:0]     lowest_ff, lowest_in;
   logic [NZ_W-1:0]      full_cnt_ff, full_cnt_in;
   logic [NZ_W-1:0]      nz_cnt_ff, nz_cnt_in;
   logic [WORD_BITS-1:0] scan_word_ff, scan_word_in;
   logic [BIT_W-1:0]     scan_bit_ff, scan_bit_in;
   logic [AW-1:0]        scan_addr_ff, scan_addr_in;

   logic [BIT_W-1:0]     bit_pos;
   logic [WORD_BITS-1:0] bit_mask;
   logic [WORD_BITS-1:0] new_word;
   logic [WORD_BITS-1:0] clear_bits;
   logic                 old_full, new_full, old_nz, new_nz;

   assign bit_pos    = idx_ff[BIT_W-1:0];
   assign bit_mask   = WORD_BITS'(1) << bit_pos;
   assign clear_bits = ~scan_word_ff & (ALL_ONES << scan_bit_ff);
   assign old_full   = (rd_data == ALL_ONES);
   assign new_full   = (new_word == ALL_ONES);
   assign old_nz     = (rd_data != ZERO_WORD);
   assign new_nz     = (new_word != ZERO_WORD);

   // new value of the addressed word
   always_comb begin
      case (mode_ff)
         MODE_SET:   new_word = rd_data | bit_mask;
         MODE_RESET: new_word = rd_data & ~bit_mask;
         MODE_FLIP:  new_word = rd_data ^ bit_mask;
         default:    new_word = rd_data;
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      idx_in       = idx_ff;
      reqcnt_in    = reqcnt_ff;
      err_in       = err_ff;
      before_in    = before_ff;
      nofree_in    = nofree_ff;
      used_in      = used_ff;
      free_in      = free_ff;
      lowest_in    = lowest_ff;
      full_cnt_in  = full_cnt_ff;
      nz_cnt_in    = nz_cnt_ff;
      scan_word_in = scan_word_ff;
      scan_bit_in  = scan_bit_ff;
      scan_addr_in = scan_addr_ff;
      req_ready    = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = idx_ff[BIT_W +: AW];
      wr_en        = 1'b0;
      wr_addr      = idx_ff[BIT_W +: AW];
      wr_data      = new_word;
      rsp_load     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            rd_addr   = req.slot_index[BIT_W +: AW];
            if (req_valid) begin
               mode_in   = req.mode;
               idx_in    = req.slot_index;
               reqcnt_in = req.request_count;
               before_in = 1'b0;
               nofree_in = 1'b0;
               err_in    = (CAP_W'(req.slot_index) >= CAP_LIMIT);
               if (CAP_W'(req.slot_index) >= CAP_LIMIT) begin
                  state_in = ST_REPORT;
               end else begin
                  rd_en    = 1'b1;
                  state_in = ST_MODIFY;
               end
            end
         end
         ST_MODIFY: begin
            before_in = rd_data[bit_pos];
            wr_en     = (mode_ff != MODE_TEST);
            state_in  = ST_REPORT;
            // whole-word tallies for the all and any flags
            if (new_full && !old_full) begin
               full_cnt_in = full_cnt_ff + NZ_W'(1);
            end else if (!new_full && old_full) begin
               full_cnt_in = full_cnt_ff - NZ_W'(1);
            end
            if (new_nz && !old_nz) begin
               nz_cnt_in = nz_cnt_ff + NZ_W'(1);
            end else if (!new_nz && old_nz) begin
               nz_cnt_in = nz_cnt_ff - NZ_W'(1);
            end
            case (mode_ff)
               MODE_SET: begin
                  if (used_ff < CNT_TOP) begin
                     used_in = used_ff + CNT_W'(1);
                  end
                  if (free_ff != '0) begin
                     free_in = free_ff - CNT_W'(1);
                  end
                  // the tracked slot got taken: search upward from it
                  if (CNT_W'(idx_ff) == lowest_ff) begin
                     scan_word_in = new_word;
                     scan_bit_in  = bit_pos;
                     scan_addr_in = idx_ff[BIT_W +: AW];
                     state_in     = ST_SCAN;
                  end
               end
               MODE_RESET: begin
                  if (used_ff != '0) begin
                     used_in = used_ff - CNT_W'(1);
                  end
                  if (free_ff < CNT_TOP) begin
                     free_in = free_ff + CNT_W'(1);
                  end
                  if (CNT_W'(idx_ff) < lowest_ff) begin
                     lowest_in = CNT_W'(idx_ff);
                  end
               end
               default: begin
               end
            endcase
         end
         ST_SCAN: begin
            rd_addr = scan_addr_ff + AW'(1);
            if (clear_bits != ZERO_WORD) begin
               lowest_in = (CNT_W'(scan_addr_ff) << BIT_W) |
                           CNT_W'(lowest_one(clear_bits));
               state_in  = ST_REPORT;
            end else if (scan_addr_ff == LAST_ADDR) begin
               // words past the addressable range stay clear; with none, no free slot is left
               if (ZERO_TAIL) begin
                  lowest_in = MEM_END;
               end else begin
                  lowest_in = CNT_TOP;
                  nofree_in = 1'b1;
               end
               state_in = ST_REPORT;
            end else begin
               rd_en        = 1'b1;
               scan_addr_in = scan_addr_ff + AW'(1);
               state_in     = ST_FETCH;
            end
         end
         ST_FETCH: begin
            scan_word_in = rd_data;
            scan_bit_in  = '0;
            state_in     = ST_SCAN;
         end
         ST_REPORT: begin
            if (rsp_space) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         used_ff     <= '0;
         free_ff     <= CNT_TOP;
         lowest_ff   <= '0;
         full_cnt_ff <= '0;
         nz_cnt_ff   <= '0;
      end else begin
         state_ff    <= state_in;
         used_ff     <= used_in;
         free_ff     <= free_in;
         lowest_ff   <= lowest_in;
         full_cnt_ff <= full_cnt_in;
         nz_cnt_ff   <= nz_cnt_in;
      end
   end

   // item and search payload
   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      idx_ff       <= idx_in;
      reqcnt_ff    <= reqcnt_in;
      err_ff       <= err_in;
      before_ff    <= before_in;
      nofree_ff    <= nofree_in;
      scan_word_ff <= scan_word_in;
      scan_bit_ff  <= scan_bit_in;
      scan_addr_ff <= scan_addr_in;
   end

   // result assembly
   always_comb begin
      rsp.bit_before     = before_ff;
      rsp.used_count     = used_ff;
      rsp.free_count     = free_ff;
      rsp.first_free     = lowest_ff;
      rsp.no_free_found  = nofree_ff;
      rsp.all_set        = !ZERO_TAIL && (full_cnt_ff == WORDS_HELD);
      rsp.any_set        = (nz_cnt_ff != '0);
      rsp.none_set       = (nz_cnt_ff == '0);
      rsp.has_space_many = (free_ff > reqcnt_ff);
      rsp.pool_full      = (free_ff == '0);
      rsp.pool_empty     = (used_ff == '0);
      rsp.index_error    = err_ff;
   end

   // used and free move in step, so they always add up to the capacity, capped at 2047
   assert property (@(posedge clock) disable iff (reset)
      ({1'b0, used_ff} + {1'b0, free_ff}) == (CNT_W + 1)'(CNT_MAX))
      else $error("used and free counters out of step");

   // a full word is also a nonzero word
   assert property (@(posedge clock) disable iff (reset)
      full_cnt_ff <= nz_cnt_ff)
      else $error("full word tally exceeds nonzero word tally");

   // only a set item runs the free search
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_FETCH) |-> (mode_ff == MODE_SET))
      else $error("free search outside a set");

   // tracked slot never goes past the none marker
   assert property (@(posedge clock) disable iff (reset)
      lowest_ff <= CNT_TOP)
      else $error("tracked free slot out of range");

endmodule

`default_nettype wire

@@ rtl/core/bitmap_slot_allocator.sv @@
// Bitmap slot allocator: each request beat tests, sets, clears or flips one
// slot of a WORD_COUNT x 32 occupancy bitmap held in a one-port-read,
// one-port-write word memory, and returns one response beat with the old bit,
// the used and free counters, the tracked lowest free slot and the pool flags.
// An item goes through one memory read, one read-modify-write of the
// addressed word and the load of the response register before the next
// item is accepted. Setting the tracked free slot adds a search: the word of
// the slot is scanned, then each further word visited is read from memory
// and bit-scanned, up to min(WORD_COUNT, 32) words in all. A response beat
// that is still waiting when the next one is ready holds the sequencer until
// rsp_tready takes it. The memory's valid bits are cleared by reset at once,
// so no clearing pass follows reset. Slot indexes at or above the capacity
// are flagged, skip the memory and leave the state unchanged.
// depends on bsa_pkg, bsa_word_mem, bsa_seq
`default_nettype none

module bitmap_slot_allocator #(
   parameter int WORD_COUNT = 32
) (
   input  wire         clock,
   input  wire         reset,
   // request: mode [1:0], slot_index [11:2], request_count [22:12], zero [23]
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [23:0] req_tdata,
   // response: bit_before [0], used_count [11:1], free_count [22:12],
   // first_free [33:23], no_free_found [34], all_set [35], any_set [36],
   // none_set [37], has_space_many [38], pool_full [39], pool_empty [40],
   // index_error [41], zero [47:42]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [47:0] rsp_tdata
);
   import bsa_pkg::*;

   localparam int MEM_WORDS = (WORD_COUNT < ADDR_WORDS) ? WORD_COUNT : ADDR_WORDS;
   localparam int AW        = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

   req_type              req;
   rsp_type              rsp;
   logic                 rsp_load;
   logic                 rsp_space;
   logic                 rd_en, wr_en;
   logic [AW-1:0]        rd_addr, wr_addr;
   logic [WORD_BITS-1:0] rd_data, wr_data;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff;

   assign req       = req_type'(req_tdata[REQ_BITS-1:0]);
   assign rsp_space = !rsp_valid_ff || rsp_tready;

   bsa_word_mem #(
      .DEPTH (MEM_WORDS),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   bsa_seq #(
      .WORD_COUNT (WORD_COUNT),
      .MEM_WORDS  (MEM_WORDS),
      .AW         (AW)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rsp_space (rsp_space),
      .rsp_load  (rsp_load),
      .rsp       (rsp)
   );

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(48 - RSP_BITS)'(0), rsp_ff};

endmodule

`default_nettype wire
